[rtl/mte_pkg.sv]
// Package for the MessagePack token encoder.
// Holds token kind codes, format tag bytes and the command record.
// No dependencies.
package mte_pkg;

  typedef enum logic [3:0] {
    OP_NIL     = 4'd0,
    OP_FALSE   = 4'd1,
    OP_TRUE    = 4'd2,
    OP_SINT    = 4'd3,
    OP_UINT    = 4'd4,
    OP_FLOAT   = 4'd5,
    OP_STR     = 4'd6,
    OP_BIN     = 4'd7,
    OP_ARRAY   = 4'd8,
    OP_MAP     = 4'd9,
    OP_PAYLOAD = 4'd10
  } op_e;

  localparam logic [7:0] TagNil     = 8'hC0;
  localparam logic [7:0] TagFalse   = 8'hC2;
  localparam logic [7:0] TagTrue    = 8'hC3;
  localparam logic [7:0] TagBin8    = 8'hC4;
  localparam logic [7:0] TagBin16   = 8'hC5;
  localparam logic [7:0] TagBin32   = 8'hC6;
  localparam logic [7:0] TagFloat64 = 8'hCB;
  localparam logic [7:0] TagUint8   = 8'hCC;
  localparam logic [7:0] TagUint16  = 8'hCD;
  localparam logic [7:0] TagUint32  = 8'hCE;
  localparam logic [7:0] TagUint64  = 8'hCF;
  localparam logic [7:0] TagInt8    = 8'hD0;
  localparam logic [7:0] TagInt16   = 8'hD1;
  localparam logic [7:0] TagInt32   = 8'hD2;
  localparam logic [7:0] TagInt64   = 8'hD3;
  localparam logic [7:0] TagStr8    = 8'hD9;
  localparam logic [7:0] TagStr16   = 8'hDA;
  localparam logic [7:0] TagStr32   = 8'hDB;
  localparam logic [7:0] TagArr16   = 8'hDC;
  localparam logic [7:0] TagArr32   = 8'hDD;
  localparam logic [7:0] TagMap16   = 8'hDE;
  localparam logic [7:0] TagMap32   = 8'hDF;
  localparam logic [7:0] FixStr     = 8'hA0;
  localparam logic [7:0] FixArr     = 8'h90;
  localparam logic [7:0] FixMap     = 8'h80;

  // One classified token: a first byte followed by nbytes of value, MSB first.
  typedef struct packed {
    logic [7:0]  tag;
    logic [3:0]  nbytes;
    logic [63:0] value;
    logic        err;
  } cmd_t;

  // Queue status seen by the back end.
  typedef struct packed {
    logic empty;
    cmd_t head;
  } q_stat_t;

endpackage

[rtl/msgpack_token_encoder_unit.sv]
// MessagePack token encoder, top level.
// Joins mte_front, mte_fifo and mte_back. Uses mte_pkg.
//
// Input channel: one token request per accepted item (in_valid_i high and
// in_stall_o low at a rising edge): operation_i, value_i, data_byte_i.
// Output channel: one encoded byte per accepted item (out_valid_o high and
// out_stall_i low), most significant first, last_byte_o on a token's final
// byte, too_long_o with a zero byte when a length exceeds 32 bits.
// Unused kinds (11..15) are accepted and produce nothing.
// A token's first byte passes through the command queue and then the
// registered output stage. A token of n bytes (1 to 9) holds the output
// stage until its last byte leaves; single-byte tokens (payload, fixints)
// sustain one request per cycle while out_stall_i is low. Multi-byte tokens
// hold the back end; the input stalls once the FifoDepth-entry queue fills.
// Reset clears the queue and the output stage; no bytes are pending.
// When the receiver stalls, the output byte holds and the queue absorbs up
// to FifoDepth further requests before in_stall_o rises.
module msgpack_token_encoder_unit #(
  parameter int unsigned FifoDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  operation_i,
  input  logic [63:0] value_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        last_byte_o,
  output logic        too_long_o
);
  import mte_pkg::*;

  logic    push, pop, full;
  cmd_t    cmd;
  q_stat_t stat;

  mte_front u_front (
    .valid_i     (in_valid_i),
    .full_i      (full),
    .operation_i (operation_i),
    .value_i     (value_i),
    .data_byte_i (data_byte_i),
    .stall_o     (in_stall_o),
    .push_o      (push),
    .cmd_o       (cmd)
  );

  mte_fifo #(.Depth(FifoDepth)) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd),
    .pop_i  (pop),
    .full_o (full),
    .stat_o (stat)
  );

  mte_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stat_i      (stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .last_byte_o (last_byte_o),
    .too_long_o  (too_long_o)
  );

endmodule

[rtl/mte_front.sv]
// Front end of the MessagePack token encoder: classifies one token request
// into a tag byte, a value byte count and an error flag. Uses mte_pkg.
module mte_front (
  input  logic              valid_i,
  input  logic              full_i,
  input  logic [3:0]        operation_i,
  input  logic [63:0]       value_i,
  input  logic [7:0]        data_byte_i,
  output logic              stall_o,
  output logic              push_o,
  output mte_pkg::cmd_t     cmd_o
);
  import mte_pkg::*;

  logic u7, u8, u16, u32;
  logic n5, n7, n15, n31;
  logic fits4, fits5;
  cmd_t c;
  logic known;

  assign u7    = (value_i[63:7] == '0);
  assign u8    = (value_i[63:8] == '0);
  assign u16   = (value_i[63:16] == '0);
  assign u32   = (value_i[63:32] == '0);
  assign fits4 = (value_i[63:4] == '0);
  assign fits5 = (value_i[63:5] == '0);
  assign n5    = &value_i[63:5];
  assign n7    = &value_i[63:7];
  assign n15   = &value_i[63:15];
  assign n31   = &value_i[63:31];

  always_comb begin
    c        = '{tag: 8'h00, nbytes: 4'd0, value: value_i, err: 1'b0};
    known    = 1'b1;
    unique case (operation_i)
      OP_NIL:   c.tag = TagNil;
      OP_FALSE: c.tag = TagFalse;
      OP_TRUE:  c.tag = TagTrue;
      OP_SINT, OP_UINT: begin
        if (operation_i == OP_SINT && value_i[63]) begin
          priority if (n5) c.tag = value_i[7:0];
          else if (n7) begin
            c.tag = TagInt8; c.nbytes = 4'd1;
          end else if (n15) begin
            c.tag = TagInt16; c.nbytes = 4'd2;
          end else if (n31) begin
            c.tag = TagInt32; c.nbytes = 4'd4;
          end else begin
            c.tag = TagInt64; c.nbytes = 4'd8;
          end
        end else begin
          priority if (u7) c.tag = value_i[7:0];
          else if (u8) begin
            c.tag = TagUint8; c.nbytes = 4'd1;
          end else if (u16) begin
            c.tag = TagUint16; c.nbytes = 4'd2;
          end else if (u32) begin
            c.tag = TagUint32; c.nbytes = 4'd4;
          end else begin
            c.tag = TagUint64; c.nbytes = 4'd8;
          end
        end
      end
      OP_FLOAT: begin
        c.tag = TagFloat64; c.nbytes = 4'd8;
      end
      OP_STR: begin
        priority if (fits5) c.tag = FixStr | value_i[7:0];
        else if (u8) begin
          c.tag = TagStr8; c.nbytes = 4'd1;
        end else if (u16) begin
          c.tag = TagStr16; c.nbytes = 4'd2;
        end else if (u32) begin
          c.tag = TagStr32; c.nbytes = 4'd4;
        end else c.err = 1'b1;
      end
      OP_BIN: begin
        priority if (u8) begin
          c.tag = TagBin8; c.nbytes = 4'd1;
        end else if (u16) begin
          c.tag = TagBin16; c.nbytes = 4'd2;
        end else if (u32) begin
          c.tag = TagBin32; c.nbytes = 4'd4;
        end else c.err = 1'b1;
      end
      OP_ARRAY, OP_MAP: begin
        priority if (fits4) begin
          c.tag = ((operation_i == OP_MAP) ? FixMap : FixArr) | value_i[7:0];
        end else if (u16) begin
          c.tag    = (operation_i == OP_MAP) ? TagMap16 : TagArr16;
          c.nbytes = 4'd2;
        end else if (u32) begin
          c.tag    = (operation_i == OP_MAP) ? TagMap32 : TagArr32;
          c.nbytes = 4'd4;
        end else c.err = 1'b1;
      end
      OP_PAYLOAD: c.tag = data_byte_i;
      default: known = 1'b0;
    endcase
  end

  assign stall_o = full_i;
  assign push_o  = valid_i & ~full_i & known;
  assign cmd_o   = c;

endmodule

[rtl/mte_fifo.sv]
// Short command queue between the encoder's front and back ends.
// Register array with read and write pointers. Uses mte_pkg.
module mte_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  mte_pkg::cmd_t      cmd_i,
  input  logic               pop_i,
  output logic               full_o,
  output mte_pkg::q_stat_t   stat_o
);
  import mte_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [AW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(Depth));
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & (cnt_q != '0);

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == AW'(Depth - 1)) ? '0 : wr_q + AW'(1);
    if (do_pop)  rd_d = (rd_q == AW'(Depth - 1)) ? '0 : rd_q + AW'(1);
    if (do_push && !do_pop) cnt_d = cnt_q + CW'(1);
    else if (do_pop && !do_push) cnt_d = cnt_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= cmd_i;
  end

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.head  = mem_q[rd_q];

endmodule

[rtl/mte_back.sv]
// Back end of the MessagePack token encoder: serializes queued commands
// into bytes through a registered output stage. Uses mte_pkg.
module mte_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mte_pkg::q_stat_t   stat_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_byte_o,
  output logic               last_byte_o,
  output logic               too_long_o
);
  import mte_pkg::*;

  logic        ov_q, ov_d;
  logic [7:0]  byte_q, byte_d;
  logic        last_q, last_d;
  logic        err_q, err_d;
  logic [63:0] val_q, val_d;
  logic [3:0]  rem_q, rem_d;
  logic [2:0]  idx;
  logic        adv;

  assign adv = ~ov_q | ~out_stall_i;
  assign idx = 3'(rem_q - 4'd1);

  always_comb begin
    ov_d   = ov_q;
    byte_d = byte_q;
    last_d = last_q;
    err_d  = err_q;
    val_d  = val_q;
    rem_d  = rem_q;
    pop_o  = 1'b0;
    if (adv) begin
      if (rem_q != 4'd0) begin
        ov_d   = 1'b1;
        byte_d = val_q[{idx, 3'b000} +: 8];
        last_d = (rem_q == 4'd1);
        err_d  = 1'b0;
        rem_d  = rem_q - 4'd1;
      end else if (!stat_i.empty) begin
        pop_o  = 1'b1;
        ov_d   = 1'b1;
        byte_d = stat_i.head.tag;
        last_d = (stat_i.head.nbytes == 4'd0);
        err_d  = stat_i.head.err;
        val_d  = stat_i.head.value;
        rem_d  = stat_i.head.nbytes;
      end else begin
        ov_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      rem_q <= '0;
    end else begin
      ov_q  <= ov_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
    err_q  <= err_d;
    val_q  <= val_d;
  end

  assign out_valid_o = ov_q;
  assign out_byte_o  = byte_q;
  assign last_byte_o = last_q;
  assign too_long_o  = err_q;

endmodule

[rtl/mte_checker.sv]
// Port-level checks for the MessagePack token encoder.
// Bound to msgpack_token_encoder_unit; no package dependency.
module mte_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       last_byte_o,
  input logic       too_long_o
);

  // Length error is a lone zero byte.
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && too_long_o) |-> (out_byte_o == 8'h00 && last_byte_o))
    else $error("too_long result is not a single zero byte");

  // Bytes of one token leave back to back.
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_byte_o) |=> out_valid_o)
    else $error("gap inside a multi-byte token");

  // Stalled output holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(out_byte_o) && $stable(last_byte_o) &&
       $stable(too_long_o)))
    else $error("stalled output changed");

  // Nothing pending once reset has been seen at an edge.
  a_reset: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind msgpack_token_encoder_unit mte_checker u_mte_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_byte_o  (out_byte_o),
  .last_byte_o (last_byte_o),
  .too_long_o  (too_long_o)
);

[tb/tb.sv]
// Self-checking testbench for msgpack_token_encoder_unit.
// Drives token requests and checks every encoded byte against an in-bench encoder.
// Depends on mte_pkg and the RTL under rtl/.
module tb;
  import mte_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 30;
  localparam int unsigned PhaseItems  = 35;
  localparam logic [3:0]  OpUnusedLo  = 4'd11;
  localparam logic [3:0]  OpUnusedHi  = 4'd15;
  localparam logic [63:0] MaxLen32    = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [3:0]  op;
    logic [63:0] value;
    logic [7:0]  data;
  } token_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } enc_byte_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [3:0]  operation_i = '0;
  logic [63:0] value_i     = '0;
  logic [7:0]  data_byte_i = '0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [7:0]  out_byte_o;
  logic        last_byte_o;
  logic        too_long_o;

  token_t    token_q[$];
  enc_byte_t expected_bytes[$];
  token_t    active_token;
  int        gap_pct      = 0;
  int        stall_pct    = 0;
  int        err_count    = 0;
  int        tokens_taken = 0;
  int        bytes_checked = 0;
  int        len_errors   = 0;
  int        cycle_count  = 0;

  msgpack_token_encoder_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .operation_i(operation_i),
    .value_i    (value_i),
    .data_byte_i(data_byte_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_byte_o (out_byte_o),
    .last_byte_o(last_byte_o),
    .too_long_o (too_long_o)
  );

  always #10 clk_i = ~clk_i;

  task automatic report_error(string msg);
    err_count++;
    if (err_count <= 30) $display("ERROR @%0d: %s", cycle_count, msg);
  endtask

  // ---- encoder prediction ----
  function automatic void push_byte(logic [7:0] b, logic last, logic err);
    enc_byte_t e;
    e.data = b;
    e.last = last;
    e.err  = err;
    expected_bytes.push_back(e);
  endfunction

  function automatic void push_tagged(logic [7:0] tag, logic [63:0] v, int nb);
    push_byte(tag, 1'b0, 1'b0);
    for (int i = nb - 1; i >= 0; i--) push_byte(v[8*i +: 8], i == 0, 1'b0);
  endfunction

  function automatic void enc_uint(logic [63:0] v);
    if (v <= 64'h7F) push_byte(v[7:0], 1'b1, 1'b0);
    else if (v <= 64'hFF) push_tagged(TagUint8, v, 1);
    else if (v <= 64'hFFFF) push_tagged(TagUint16, v, 2);
    else if (v <= MaxLen32) push_tagged(TagUint32, v, 4);
    else push_tagged(TagUint64, v, 8);
  endfunction

  function automatic void enc_sint(logic [63:0] v);
    if (!v[63]) enc_uint(v);
    else if (v >= 64'hFFFF_FFFF_FFFF_FFE0) push_byte(v[7:0], 1'b1, 1'b0);
    else if (v >= 64'hFFFF_FFFF_FFFF_FF80) push_tagged(TagInt8, v, 1);
    else if (v >= 64'hFFFF_FFFF_FFFF_8000) push_tagged(TagInt16, v, 2);
    else if (v >= 64'hFFFF_FFFF_8000_0000) push_tagged(TagInt32, v, 4);
    else push_tagged(TagInt64, v, 8);
  endfunction

  function automatic void enc_count(logic [63:0] n, logic [7:0] fix,
                                    logic [7:0] tag16, logic [7:0] tag32);
    if (n <= 64'hF) push_byte(fix | n[7:0], 1'b1, 1'b0);
    else if (n <= 64'hFFFF) push_tagged(tag16, n, 2);
    else if (n <= MaxLen32) push_tagged(tag32, n, 4);
    else push_byte(8'h00, 1'b1, 1'b1);
  endfunction

  function automatic void encode_token(token_t t);
    case (t.op)
      OP_NIL:     push_byte(TagNil, 1'b1, 1'b0);
      OP_FALSE:   push_byte(TagFalse, 1'b1, 1'b0);
      OP_TRUE:    push_byte(TagTrue, 1'b1, 1'b0);
      OP_SINT:    enc_sint(t.value);
      OP_UINT:    enc_uint(t.value);
      OP_FLOAT:   push_tagged(TagFloat64, t.value, 8);
      OP_STR: begin
        if (t.value <= 64'h1F) push_byte(FixStr | t.value[7:0], 1'b1, 1'b0);
        else if (t.value <= 64'hFF) push_tagged(TagStr8, t.value, 1);
        else if (t.value <= 64'hFFFF) push_tagged(TagStr16, t.value, 2);
        else if (t.value <= MaxLen32) push_tagged(TagStr32, t.value, 4);
        else push_byte(8'h00, 1'b1, 1'b1);
      end
      OP_BIN: begin
        if (t.value <= 64'hFF) push_tagged(TagBin8, t.value, 1);
        else if (t.value <= 64'hFFFF) push_tagged(TagBin16, t.value, 2);
        else if (t.value <= MaxLen32) push_tagged(TagBin32, t.value, 4);
        else push_byte(8'h00, 1'b1, 1'b1);
      end
      OP_ARRAY:   enc_count(t.value, FixArr, TagArr16, TagArr32);
      OP_MAP:     enc_count(t.value, FixMap, TagMap16, TagMap32);
      OP_PAYLOAD: push_byte(t.data, 1'b1, 1'b0);
      default: ;
    endcase
  endfunction

  // ---- stimulus helpers ----
  function automatic void push_token(logic [3:0] op, logic [63:0] v, logic [7:0] d);
    token_t t;
    t.op    = op;
    t.value = v;
    t.data  = d;
    token_q.push_back(t);
  endfunction

  function automatic logic [63:0] rand_wide();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] rand_int_value();
    logic [63:0] v;
    v = rand_wide();
    case ($urandom_range(3))
      0: v = v >> $urandom_range(63);
      1: v = ~(v >> $urandom_range(63));
      2: v = (64'd1 << $urandom_range(63)) + 64'($urandom_range(2)) - 64'd1;
      default: v = -((64'd1 << $urandom_range(63)) + 64'($urandom_range(2)) - 64'd1);
    endcase
    return v;
  endfunction

  function automatic logic [63:0] rand_len();
    if ($urandom_range(1))
      return (64'd1 << $urandom_range(36, 4)) + 64'($urandom_range(2)) - 64'd1;
    return rand_wide() >> $urandom_range(63);
  endfunction

  function automatic void add_scalar();
    logic [3:0] op;
    logic [63:0] v;
    op = 4'($urandom_range(OP_FLOAT, OP_NIL));
    if (op == OP_SINT || op == OP_UINT) v = rand_int_value();
    else v = rand_wide();
    push_token(op, v, 8'($urandom()));
  endfunction

  // One token group; returns how many tokens the block acts on.
  function automatic int add_sequence();
    int kind;
    int len;
    int n;
    logic [3:0] op;
    kind = $urandom_range(99);
    n = 0;
    if (kind < 40) begin
      add_scalar();
      n = 1;
    end else if (kind < 65) begin
      len = $urandom_range(6);
      op = $urandom_range(1) ? OP_STR : OP_BIN;
      push_token(op, 64'(len), 8'($urandom()));
      for (int i = 0; i < len; i++) push_token(OP_PAYLOAD, rand_wide(), 8'($urandom()));
      n = len + 1;
    end else if (kind < 80) begin
      len = $urandom_range(3);
      op = $urandom_range(1) ? OP_ARRAY : OP_MAP;
      push_token(op, 64'(len), 8'($urandom()));
      if (op == OP_MAP) len = 2 * len;
      for (int i = 0; i < len; i++) add_scalar();
      n = len + 1;
    end else if (kind < 92) begin
      push_token(4'($urandom_range(OP_MAP, OP_STR)), rand_len(), 8'($urandom()));
      n = 1;
    end else if ($urandom_range(1)) begin
      push_token(4'($urandom_range(OpUnusedHi, OpUnusedLo)), rand_wide(), 8'($urandom()));
    end else begin
      push_token(OP_PAYLOAD, rand_wide(), 8'($urandom()));
      n = 1;
    end
    return n;
  endfunction

  task automatic wait_idle();
    @(negedge clk_i);
    while (token_q.size() != 0 || in_valid_i || expected_bytes.size() != 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // ---- request driver ----
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      operation_i <= '0;
      value_i     <= '0;
      data_byte_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        encode_token(active_token);
        tokens_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (token_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
          active_token = token_q.pop_front();
          in_valid_i  <= 1'b1;
          operation_i <= active_token.op;
          value_i     <= active_token.value;
          data_byte_i <= active_token.data;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---- receiver stall ----
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // ---- output monitor ----
  always @(posedge clk_i) begin
    enc_byte_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_bytes.size() == 0) begin
        report_error($sformatf("unexpected byte %02h", out_byte_o));
      end else begin
        want = expected_bytes.pop_front();
        bytes_checked++;
        if (want.err) len_errors++;
        if (out_byte_o !== want.data)
          report_error($sformatf("out_byte %02h, want %02h", out_byte_o, want.data));
        if (last_byte_o !== want.last)
          report_error($sformatf("last_byte %b, want %b", last_byte_o, want.last));
        if (too_long_o !== want.err)
          report_error($sformatf("too_long %b, want %b", too_long_o, want.err));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d bytes outstanding",
               cycle_count, expected_bytes.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int taken;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed corners
    push_token(OP_NIL, '1, 8'hFF);
    push_token(OP_FALSE, 64'h0, 8'h00);
    push_token(OP_TRUE, 64'h5555_AAAA_5555_AAAA, 8'hA5);
    push_token(OP_UINT, 64'h7F, 8'h00);
    push_token(OP_UINT, 64'h80, 8'h00);
    push_token(OP_UINT, 64'h1_0000, 8'h00);
    push_token(OP_UINT, '1, 8'h00);
    push_token(OP_SINT, 64'hFFFF_FFFF_FFFF_FFE0, 8'h00);
    push_token(OP_SINT, 64'hFFFF_FFFF_FFFF_FFDF, 8'h00);
    push_token(OP_SINT, 64'hFFFF_FFFF_FFFF_FF7F, 8'h00);
    push_token(OP_SINT, 64'h8000_0000_0000_0000, 8'h00);
    push_token(OP_SINT, 64'h7FFF_FFFF_FFFF_FFFF, 8'h00);
    push_token(OP_FLOAT, 64'h0123_4567_89AB_CDEF, 8'h00);
    push_token(OP_STR, 64'd31, 8'hFF);
    push_token(OP_STR, MaxLen32, 8'h00);
    push_token(OP_STR, MaxLen32 + 64'd1, 8'h00);
    push_token(OP_BIN, 64'd0, 8'h00);
    push_token(OP_BIN, 64'h1_0000, 8'h00);
    push_token(OP_ARRAY, 64'd15, 8'h00);
    push_token(OP_ARRAY, 64'd16, 8'h00);
    push_token(OP_MAP, 64'h1_0000, 8'h00);
    push_token(OP_MAP, '1, 8'h00);
    push_token(OP_PAYLOAD, '1, 8'h00);
    push_token(OP_PAYLOAD, 64'h0, 8'hFF);
    push_token(OpUnusedHi, '1, 8'hFF);
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin gap_pct <= 0;  stall_pct <= 0;  end
        1: begin gap_pct <= 83; stall_pct <= 0;  end
        2: begin gap_pct <= 0;  stall_pct <= 83; end
        default: begin gap_pct <= 10; stall_pct <= 10; end
      endcase
      taken = 0;
      while (taken < PhaseItems) taken += add_sequence();
      wait_idle();
    end

    $display("Covered %0d tokens in four idle/stall mixes: %0d bytes checked, %0d length errors",
             tokens_taken, bytes_checked, len_errors);
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

[sim.f]
rtl/mte_pkg.sv
rtl/mte_front.sv
rtl/mte_fifo.sv
rtl/mte_back.sv
rtl/msgpack_token_encoder_unit.sv
rtl/mte_checker.sv
tb/tb.sv
